@@ rtl/avm_pkg.sv @@
`default_nettype none
package avm_pkg;

  // Field and register widths
  localparam int CODE_W   = 14;
  localparam int GAIN_W   = 12;
  localparam int OFFSET_W = 16;
  localparam int LEN_W    = 11;
  localparam int CFG_W    = 16;
  localparam int VAL_W    = 24;
  localparam int CHAR_W   = 8;
  localparam int WHICH_W  = 2;

  // Number formatting and window limits
  localparam int DECIMAL_DIGITS = 7;
  localparam int SHOWN_DIGITS   = 3;
  localparam int MAX_WINDOW     = 1024;
  localparam int CNT_W          = $clog2(MAX_WINDOW);
  localparam int POS_W          = $clog2(SHOWN_DIGITS + 2);

  // Scaling datapath
  localparam int PROD_W   = CODE_W + GAIN_W;
  localparam int QUO_W    = PROD_W - 3;
  localparam int RECIP_SH = PROD_W + 4;
  localparam int RECIP_W  = RECIP_SH - 3;

  // Output queue between window logic and text formatter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset values
  localparam logic [LEN_W-1:0]    WINDOW_LENGTH_RST = LEN_W'(20);
  localparam logic [GAIN_W-1:0]   SCALE_GAIN_RST    = GAIN_W'(2014);
  localparam logic [OFFSET_W-1:0] SCALE_OFFSET_RST  = OFFSET_W'(32742);

  // ASCII characters
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_V    = 8'h56;

  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

  localparam logic [VAL_W-1:0] VAL_TOP  = VAL_W'(pow10(DECIMAL_DIGITS) - 1);
  localparam logic [VAL_W-1:0] LEAD_POW = VAL_W'(pow10(DECIMAL_DIGITS - 1));
  // ceil(2^RECIP_SH / 10): exact quotient for every PROD_W-bit dividend
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'd9) / 64'd10);

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH = 2'd0,
    REG_SCALE_GAIN    = 2'd1,
    REG_SCALE_OFFSET  = 2'd2
  } cfg_reg_t;

  typedef enum logic [WHICH_W-1:0] {
    READ_MIN = 2'd0,
    READ_MAX = 2'd1,
    READ_MID = 2'd2
  } reading_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [LEN_W-1:0]    window_length;
    logic [GAIN_W-1:0]   scale_gain;
    logic [OFFSET_W-1:0] scale_offset;
  } front_cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] mx;
    logic [VAL_W-1:0] mn;
  } minmax_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Leading decimal digit of a value below 10^DECIMAL_DIGITS
  function automatic logic [3:0] lead_digit(input logic [VAL_W-1:0] r);
    logic [3:0] d;
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if ((VAL_W+4)'(r) >= (VAL_W+4)'(k) * (VAL_W+4)'(LEAD_POW)) begin
        d = 4'(k);
      end
    end
    return d;
  endfunction

  // Drop the leading digit and move the next one up
  function automatic logic [VAL_W-1:0] next_rem(input logic [VAL_W-1:0] r,
                                                input logic [3:0] d);
    logic [VAL_W+3:0] w;
    logic [VAL_W-1:0] sub;
    logic [VAL_W+3:0] t;
    w   = (VAL_W+4)'(d) * (VAL_W+4)'(LEAD_POW);
    sub = r - w[VAL_W-1:0];
    t   = (VAL_W+4)'(sub) * (VAL_W+4)'(10);
    return t[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/avm_front.sv @@
`default_nettype none
module avm_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire avm_pkg::front_cfg_t   cfg,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [avm_pkg::CODE_W-1:0] in_code,
  output logic                       push,
  output avm_pkg::minmax_t           push_data,
  input  wire avm_pkg::queue_status_t q_status
);

  localparam int VW = avm_pkg::VAL_W;
  localparam int PW = avm_pkg::PROD_W;
  localparam int MW = avm_pkg::PROD_W + avm_pkg::RECIP_W;

  logic v1, v2, v3, v4;
  logic [PW-1:0] prod1;
  logic [PW-1:0] diff2;
  logic [avm_pkg::QUO_W-1:0] quo3;
  logic [VW-1:0] val4;

  logic [avm_pkg::CNT_W-1:0] count;
  logic [VW-1:0] running_min;
  logic [VW-1:0] running_max;

  logic adv;
  logic win_end;
  logic [avm_pkg::LEN_W-1:0] len_eff;
  logic [avm_pkg::LEN_W-1:0] cnt_plus;
  logic [VW-1:0] min_next, max_next;
  logic [MW-1:0] recip_prod;
  logic [VW-1:0] quo_ext;

  // Effective window length, clamped to 1..MAX_WINDOW
  always_comb begin
    priority if (cfg.window_length == '0) begin
      len_eff = avm_pkg::LEN_W'(1);
    end else if (cfg.window_length > avm_pkg::LEN_W'(avm_pkg::MAX_WINDOW)) begin
      len_eff = avm_pkg::LEN_W'(avm_pkg::MAX_WINDOW);
    end else begin
      len_eff = cfg.window_length;
    end
  end

  assign cnt_plus = avm_pkg::LEN_W'(count) + avm_pkg::LEN_W'(1);
  assign win_end  = cnt_plus >= len_eff;

  // Pipeline stalls only when a closing sample finds the queue full
  assign adv      = !(v4 && win_end && q_status.full);
  assign in_ready = adv;
  assign push     = v4 && win_end && !q_status.full;

  // Divide by ten through the reciprocal
  assign recip_prod = MW'(diff2) * MW'(avm_pkg::RECIP_M);
  assign quo_ext    = VW'(quo3);

  assign min_next = (val4 < running_min) ? val4 : running_min;
  assign max_next = (val4 > running_max) ? val4 : running_max;
  assign push_data.mn = min_next;
  assign push_data.mx = max_next;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Scaling stages: multiply, offset, divide, saturate
  always_ff @(posedge clk) begin
    if (adv) begin
      prod1 <= PW'(in_code) * PW'(cfg.scale_gain);
      diff2 <= (prod1 > PW'(cfg.scale_offset)) ? prod1 - PW'(cfg.scale_offset) : '0;
      quo3  <= recip_prod[avm_pkg::RECIP_SH +: avm_pkg::QUO_W];
      val4  <= (quo_ext > avm_pkg::VAL_TOP) ? avm_pkg::VAL_TOP : quo_ext;
    end
  end

  // Window state: count, running minimum and maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      running_min <= '1;
      running_max <= '0;
    end else if (adv && v4) begin
      if (win_end) begin
        count       <= '0;
        running_min <= '1;
        running_max <= '0;
      end else begin
        count       <= cnt_plus[avm_pkg::CNT_W-1:0];
        running_min <= min_next;
        running_max <= max_next;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/avm_queue.sv @@
`default_nettype none
module avm_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire avm_pkg::minmax_t  push_data,
  input  wire logic              pop,
  output avm_pkg::minmax_t       pop_data,
  output avm_pkg::queue_status_t status
);

  avm_pkg::minmax_t mem [avm_pkg::QUEUE_DEPTH];
  logic [avm_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [avm_pkg::QCNT_W-1:0] fill;

  assign status.full  = fill == avm_pkg::QCNT_W'(avm_pkg::QUEUE_DEPTH);
  assign status.empty = fill == '0;
  assign pop_data     = mem[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + avm_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + avm_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + avm_pkg::QCNT_W'(1);
        2'b01:   fill <= fill - avm_pkg::QCNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/avm_back.sv @@
`default_nettype none
module avm_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire avm_pkg::queue_status_t q_status,
  output logic                        pop,
  input  wire avm_pkg::minmax_t       pop_data,
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [avm_pkg::CHAR_W-1:0]  m_tdata,
  output logic [avm_pkg::WHICH_W-1:0] m_tuser,
  output logic                        m_tlast
);

  localparam int VW = avm_pkg::VAL_W;
  localparam int PW = avm_pkg::POS_W;
  localparam logic [PW-1:0] POS_DOT  = PW'(1);
  localparam logic [PW-1:0] POS_UNIT = PW'(avm_pkg::SHOWN_DIGITS + 1);

  avm_pkg::back_state_t state, state_next;
  avm_pkg::reading_t    which, which_next;
  logic [PW-1:0] pos;
  logic [VW-1:0] mn, mx, mid, rem;

  logic out_free;
  logic emit;
  logic last_pos;
  logic final_char;
  logic [3:0] digit;
  logic [avm_pkg::CHAR_W-1:0] char_val;
  logic [VW:0] mid_sum;

  assign out_free   = !m_tvalid || m_tready;
  assign last_pos   = pos == POS_UNIT;
  assign final_char = last_pos && (which == avm_pkg::READ_MID);
  assign digit      = avm_pkg::lead_digit(rem);
  assign mid_sum    = (VW+1)'(mn) + (VW+1)'(mx);

  // Character at the current position
  always_comb begin
    priority if (pos == POS_DOT) begin
      char_val = avm_pkg::CHAR_DOT;
    end else if (last_pos) begin
      char_val = avm_pkg::CHAR_V;
    end else begin
      char_val = avm_pkg::CHAR_ZERO + avm_pkg::CHAR_W'(digit);
    end
  end

  always_comb begin
    unique case (which)
      avm_pkg::READ_MIN: which_next = avm_pkg::READ_MAX;
      avm_pkg::READ_MAX: which_next = avm_pkg::READ_MID;
      default:           which_next = avm_pkg::READ_MIN;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      avm_pkg::BK_IDLE: begin
        if (!q_status.empty) state_next = avm_pkg::BK_EMIT;
      end
      avm_pkg::BK_EMIT: begin
        if (out_free && final_char && q_status.empty) state_next = avm_pkg::BK_IDLE;
      end
      default: state_next = avm_pkg::BK_IDLE;
    endcase
  end

  // Control outputs: next window is loaded right after the last word
  always_comb begin
    pop  = 1'b0;
    emit = 1'b0;
    unique case (state)
      avm_pkg::BK_IDLE: begin
        pop = !q_status.empty;
      end
      avm_pkg::BK_EMIT: begin
        emit = out_free;
        pop  = out_free && final_char && !q_status.empty;
      end
      default: begin
        pop  = 1'b0;
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avm_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Reading and character position
  always_ff @(posedge clk) begin
    if (rst) begin
      which <= avm_pkg::READ_MIN;
      pos   <= '0;
    end else if (pop) begin
      which <= avm_pkg::READ_MIN;
      pos   <= '0;
    end else if (emit) begin
      if (last_pos) begin
        which <= which_next;
        pos   <= '0;
      end else begin
        pos <= pos + PW'(1);
      end
    end
  end

  // Values being formatted; mid settles long before it is needed
  always_ff @(posedge clk) begin
    mid <= mid_sum[VW:1];
    if (pop) begin
      mn  <= pop_data.mn;
      mx  <= pop_data.mx;
      rem <= pop_data.mn;
    end else if (emit) begin
      if (last_pos) begin
        rem <= (which == avm_pkg::READ_MIN) ? mx : mid;
      end else if (pos != POS_DOT) begin
        rem <= avm_pkg::next_rem(rem, digit);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= char_val;
      m_tuser <= which;
      m_tlast <= final_char;
    end
  end

endmodule
`default_nettype wire

@@ rtl/adc_window_minmax_voltmeter.sv @@
// Takes one sample word per cycle while s_tready is high; the pipeline registers the multiply,
// offset, divide and saturate results. The first character leaves once the closing sample has
// passed those stages and the queue; the rest of the window's 15 characters follow at one per
// cycle while the output is taken. A four-entry queue holds finished windows; with windows under
// 15 samples the text side sets the pace; ready drops when a closing sample meets a full queue.
// Synchronous active-high reset: registers to defaults, window state cleared, queue empty.
`default_nettype none
module adc_window_minmax_voltmeter (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream, tdata: sample_code[13:0], zero fill [15:14]
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // text_char[7:0]
  output logic [1:0]       m_tuser,   // which_reading[1:0]
  output logic             m_tlast,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  avm_pkg::front_cfg_t    cfg;
  avm_pkg::minmax_t       push_data, pop_data;
  avm_pkg::queue_status_t q_status;
  logic push, pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length <= avm_pkg::WINDOW_LENGTH_RST;
      cfg.scale_gain    <= avm_pkg::SCALE_GAIN_RST;
      cfg.scale_offset  <= avm_pkg::SCALE_OFFSET_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (avm_pkg::cfg_reg_t'(cfg_index))
        avm_pkg::REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[avm_pkg::LEN_W-1:0];
        avm_pkg::REG_SCALE_GAIN:    cfg.scale_gain    <= cfg_data[avm_pkg::GAIN_W-1:0];
        avm_pkg::REG_SCALE_OFFSET:  cfg.scale_offset  <= cfg_data[avm_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  avm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_code   (s_tdata[avm_pkg::CODE_W-1:0]),
    .push      (push),
    .push_data (push_data),
    .q_status  (q_status)
  );

  avm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  avm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .pop      (pop),
    .pop_data (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Final word of a window is the unit mark of the midrange reading
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == avm_pkg::READ_MID && m_tdata == avm_pkg::CHAR_V)
    else $error("last word is not the midrange unit mark");

  // Input backpressure only comes from a full queue
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_status.full)
    else $error("input stalled with room in the queue");

  // Queue never pushed when full nor popped when empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("queue overflow or underflow");

endmodule
`default_nettype wire
